// ----- rtl/skvg_pkg.sv -----
package skvg_pkg;

    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAG = 32'h8000_0000;

    localparam logic [31:0] RADIUS_RST = 32'd65536;
    localparam logic [31:0] RECIP_RST  = 32'd65536;
    localparam logic [31:0] NORM_RST   = 32'd166886;

    // register word index (byte address / 4)
    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_RECIP  = 2'd1,
        REG_NORM   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] radius;
        logic [31:0] recip;
        logic [31:0] norm;
    } t_cfg;

    // side information that rides along the divider
    typedef struct packed {
        logic [31:0] val;
        logic        vsat;
        logic        gzero;
        logic        ovf;
    } t_side;

endpackage

// ----- rtl/skvg_regs.sv -----
module skvg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output skvg_pkg::t_cfg    o_cfg
);
    import skvg_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius <= RADIUS_RST;
            r_cfg.recip  <= RECIP_RST;
            r_cfg.norm   <= NORM_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_RADIUS: r_cfg.radius <= pwdata;
                REG_RECIP:  r_cfg.recip  <= pwdata;
                REG_NORM:   r_cfg.norm   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_RADIUS: prdata = r_cfg.radius;
            REG_RECIP:  prdata = r_cfg.recip;
            REG_NORM:   prdata = r_cfg.norm;
            default:    prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/skvg_front.sv -----
module skvg_front #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [31:0]       i_distance,
    input  skvg_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    output skvg_pkg::t_side   o_side,
    output logic [63:0]       o_rem,
    output logic [63:0]       o_div,
    output logic [31:0]       o_nlo
);
    import skvg_pkg::*;

    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned PW = F + 1;
    localparam int unsigned GW = F + 3;
    localparam int unsigned VW = PW + 32;
    localparam int unsigned MW = GW + 32;
    localparam int unsigned NW = MW + F;
    localparam int unsigned HW = NW - 32;
    localparam logic [PW-1:0] ONE_P = {1'b1, {F{1'b0}}};
    localparam logic [GW-1:0] ONE_G = GW'(ONE_P);
    localparam logic [GW-1:0] SIX_G = GW'(6);
    localparam logic [GW-1:0] THR_G = GW'(3);

    // stage 1: distance times reciprocal
    logic        r_v1;
    logic [63:0] r_p;
    logic [31:0] r_r1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_p  <= 64'(i_distance) * 64'(i_cfg.recip);
        r_r1 <= i_distance;
    end

    // stage 2: q, branch, divisor h*r
    logic [F-1:0] w_qf, w_x;
    logic         w_in, w_lo;
    logic         r_v2, r_in2, r_lo2, r_rz2;
    logic [F-1:0] r_x2i;
    logic [63:0]  r_d2;

    assign w_in = (r_p[63:2*F] == '0);
    assign w_qf = r_p[2*F-1:F];
    assign w_lo = ~w_qf[F-1];
    assign w_x  = w_lo ? w_qf : F'(ONE_P - PW'(w_qf));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_in2 <= w_in;
        r_lo2 <= w_lo;
        r_rz2 <= (r_r1 == 32'd0);
        r_x2i <= w_x;
        r_d2  <= 64'(i_cfg.radius) * 64'(r_r1);
    end

    // stage 3: square
    logic [2*F-1:0] w_sq;
    logic           r_v3, r_in3, r_lo3, r_rz3;
    logic [F-1:0]   r_x3i, r_sq3;
    logic [63:0]    r_d3;

    assign w_sq = r_x2i * r_x2i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_in3 <= r_in2;
        r_lo3 <= r_lo2;
        r_rz3 <= r_rz2;
        r_x3i <= r_x2i;
        r_sq3 <= w_sq[2*F-1:F];
        r_d3  <= r_d2;
    end

    // stage 4: cube
    logic [2*F-1:0] w_cu;
    logic           r_v4, r_in4, r_lo4, r_rz4;
    logic [F-1:0]   r_x4i, r_sq4, r_cu4;
    logic [63:0]    r_d4;

    assign w_cu = r_sq3 * r_x3i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_in4 <= r_in3;
        r_lo4 <= r_lo3;
        r_rz4 <= r_rz3;
        r_x4i <= r_x3i;
        r_sq4 <= r_sq3;
        r_cu4 <= w_cu[2*F-1:F];
        r_d4  <= r_d3;
    end

    // stage 5: polynomial and derivative term
    logic [GW-1:0] w_six, w_gl, w_gq;
    logic [PW-1:0] w_poly;
    logic          r_v5, r_rz5;
    logic [PW-1:0] r_poly5;
    logic [GW-1:0] r_gq5;
    logic [63:0]   r_d5;

    assign w_six = (GW'(r_sq4) - GW'(r_cu4)) * SIX_G;
    assign w_gl  = (GW'(r_x4i) << 1) - GW'(r_sq4) * THR_G;

    always_comb begin
        if (!r_in4) begin
            w_poly = '0;
            w_gq   = '0;
        end else if (r_lo4) begin
            w_poly = PW'(ONE_G - w_six);
            w_gq   = w_gl * SIX_G;
        end else begin
            w_poly = {r_cu4, 1'b0};
            w_gq   = GW'(r_sq4) * SIX_G;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_rz5   <= r_rz4;
        r_poly5 <= w_poly;
        r_gq5   <= w_gq;
        r_d5    <= r_d4;
    end

    // stage 6: scale by sigma
    logic [VW-1:0] w_vp;
    logic          r_v6, r_gz6;
    logic [32:0]   r_val6;
    logic [MW-1:0] r_m6;
    logic [63:0]   r_d6;

    assign w_vp = VW'(r_poly5) * VW'(i_cfg.norm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
        r_gz6  <= r_rz5 || (r_gq5 == '0);
        r_val6 <= w_vp[F+32:F];
        r_m6   <= MW'(r_gq5) * MW'(i_cfg.norm);
        r_d6   <= r_d5;
    end

    // stage 7: clip value, set up the quotient
    logic [NW-1:0] w_n;
    logic [HW-1:0] w_nhi;
    t_side         w_side;

    assign w_n   = {r_m6, {F{1'b0}}};
    assign w_nhi = w_n[NW-1:32];

    always_comb begin
        w_side.vsat  = r_val6[32] | r_val6[31];
        w_side.val   = w_side.vsat ? POS_MAX : r_val6[31:0];
        w_side.gzero = r_gz6;
        w_side.ovf   = (64'(w_nhi) >= r_d6);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v6;
        end
        o_side <= w_side;
        o_rem  <= 64'(w_nhi);
        o_div  <= r_d6;
        o_nlo  <= w_n[31:0];
    end

endmodule

// ----- rtl/skvg_div.sv -----
module skvg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  skvg_pkg::t_side   i_side,
    input  logic [63:0]       i_rem,
    input  logic [63:0]       i_div,
    input  logic [31:0]       i_nlo,
    output logic              o_valid,
    output logic [31:0]       o_kernel_value,
    output logic [31:0]       o_grad_factor,
    output logic              o_saturated
);
    import skvg_pkg::*;

    localparam int unsigned STEPS = 32;

    logic        r_vld [0:STEPS-1];
    logic [63:0] r_rem [0:STEPS-1];
    logic [63:0] r_dv  [0:STEPS-1];
    logic [31:0] r_nlo [0:STEPS-1];
    logic [31:0] r_quo [0:STEPS-1];
    t_side       r_sd  [0:STEPS-1];

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic        c_vld;
        logic [63:0] c_rem, c_dv;
        logic [31:0] c_nlo, c_quo;
        t_side       c_sd;
        logic [64:0] w_t, w_diff;
        logic        w_ge;

        if (k == 0) begin : g_first
            assign c_vld = i_valid;
            assign c_rem = i_rem;
            assign c_dv  = i_div;
            assign c_nlo = i_nlo;
            assign c_quo = 32'd0;
            assign c_sd  = i_side;
        end else begin : g_next
            assign c_vld = r_vld[k-1];
            assign c_rem = r_rem[k-1];
            assign c_dv  = r_dv[k-1];
            assign c_nlo = r_nlo[k-1];
            assign c_quo = r_quo[k-1];
            assign c_sd  = r_sd[k-1];
        end

        assign w_t    = {c_rem, c_nlo[STEPS-1-k]};
        assign w_diff = w_t - {1'b0, c_dv};
        assign w_ge   = (w_t >= {1'b0, c_dv});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= c_vld;
            end
            r_rem[k] <= w_ge ? w_diff[63:0] : w_t[63:0];
            r_dv[k]  <= c_dv;
            r_nlo[k] <= c_nlo;
            r_quo[k] <= {c_quo[30:0], w_ge};
            r_sd[k]  <= c_sd;
        end
    end

    // clip magnitude and negate
    logic [31:0] w_quo, w_mag;
    t_side       w_sd;
    logic        w_big;

    assign w_quo = r_quo[STEPS-1];
    assign w_sd  = r_sd[STEPS-1];
    assign w_big = w_sd.ovf || (w_quo > NEG_MAG);
    assign w_mag = w_sd.gzero ? 32'd0 : (w_big ? NEG_MAG : w_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld[STEPS-1];
        end
        o_kernel_value <= w_sd.val;
        o_grad_factor  <= 32'd0 - w_mag;
        o_saturated    <= w_sd.vsat || (!w_sd.gzero && w_big);
    end

endmodule

// ----- rtl/sph_kernel_value_gradient.sv -----
// channel   direction  handshake             payload
// -------   ---------  --------------------  ---------------------------------------
// input     in         start && !busy        i_distance
// result    out        o_done (strobe)       o_kernel_value, o_grad_factor, o_saturated
// config    in         apb write, pready=1   pwdata at paddr (radius, reciprocal, sigma)
//
// one word accepted every cycle; busy stays low
// result passes through 7 front stages, 32 divider stages and 1 output register
// the one-bit-per-stage gradient divider sets the depth
// synchronous active-low reset clears the valid bits and the configuration registers to their defaults
// results cannot be held off, so the pipe never stalls
module sph_kernel_value_gradient #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_distance,
    output logic        o_done,
    output logic signed [31:0] o_kernel_value,
    output logic signed [31:0] o_grad_factor,
    output logic        o_saturated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import skvg_pkg::*;

    localparam int unsigned LATENCY = 40;

    t_cfg        w_cfg;
    logic        w_accept;
    logic        w_fvld;
    t_side       w_side;
    logic [63:0] w_rem, w_div;
    logic [31:0] w_nlo, w_kv, w_gf;

    // fully pipelined, never refuses a word
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // configuration registers
    skvg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // q, spline polynomial, sigma scaling, divisor h*r
    skvg_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_distance (i_distance),
        .i_cfg      (w_cfg),
        .o_valid    (w_fvld),
        .o_side     (w_side),
        .o_rem      (w_rem),
        .o_div      (w_div),
        .o_nlo      (w_nlo)
    );

    // gradient quotient, clipping and negation
    skvg_div u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_fvld),
        .i_side         (w_side),
        .i_rem          (w_rem),
        .i_div          (w_div),
        .i_nlo          (w_nlo),
        .o_valid        (o_done),
        .o_kernel_value (w_kv),
        .o_grad_factor  (w_gf),
        .o_saturated    (o_saturated)
    );

    assign o_kernel_value = $signed(w_kv);
    assign o_grad_factor  = $signed(w_gf);

`ifndef SYNTHESIS
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_done)
        else $error("word accepted without result");
    a_lat_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, LATENCY))
        else $error("result without accepted word");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_saturated) |-> (w_kv == POS_MAX || w_gf == NEG_MAG))
        else $error("saturated flag without clipped output");
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!w_kv[31] && (w_gf[31] || w_gf == 32'd0)))
        else $error("output sign wrong");
`endif

endmodule

// ----- tb/kernel_checker.sv -----
module kernel_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [31:0]        i_distance,
    input  logic               o_done,
    input  logic signed [31:0] o_kernel_value,
    input  logic signed [31:0] o_grad_factor,
    input  logic               o_saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 o_fail_count,
    output int                 o_pending
);
    import skvg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;

    typedef struct packed {
        logic [31:0] kval;
        logic [31:0] grad;
        logic        sat;
    } t_kernel_word;

    t_kernel_word expected_kernel[$];
    t_cfg         cfg_mirror;
    int           fail_count;

    function automatic t_kernel_word predict_kernel(logic [31:0] r, t_cfg c);
        logic [63:0]  q, q2, q3, poly, val, gq, t, t2, t3, m, d, gmag;
        logic [127:0] quo;
        logic [63:0]  cap;
        logic         sat;
        t_kernel_word w;
        cap  = 64'h8000_0001;
        val  = '0;
        gmag = '0;
        gq   = '0;
        sat  = 1'b0;
        q = ({32'b0, r} * {32'b0, c.recip}) >> FB;
        if (q < 64'h1_0000) begin
            if (q < 64'h8000) begin
                q2   = (q * q) >> FB;
                q3   = (q2 * q) >> FB;
                poly = 64'h1_0000 - 6 * (q2 - q3);
                val  = (poly * {32'b0, c.norm}) >> FB;
                gq   = 6 * (2 * q - 3 * q2);
            end else begin
                t   = 64'h1_0000 - q;
                t2  = (t * t) >> FB;
                t3  = (t2 * t) >> FB;
                val = (2 * t3 * {32'b0, c.norm}) >> FB;
                gq  = 6 * t2;
            end
            if (r != 0 && gq != 0) begin
                m = gq * {32'b0, c.norm};
                d = {32'b0, c.radius} * {32'b0, r};
                if (d == 0) begin
                    gmag = cap;
                end else begin
                    quo  = ({64'b0, m} << FB) / {64'b0, d};
                    gmag = (quo > {64'b0, cap}) ? cap : quo[63:0];
                end
                // magnitude past 2^31 clips to the most negative value
                if (gmag > {32'b0, NEG_MAG}) begin
                    gmag = {32'b0, NEG_MAG};
                    sat  = 1'b1;
                end
            end
        end
        if (val > {32'b0, POS_MAX}) begin
            val = {32'b0, POS_MAX};
            sat = 1'b1;
        end
        w.kval = val[31:0];
        w.grad = 32'd0 - gmag[31:0];
        w.sat  = sat;
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_kernel_word exp_w;
        if (!i_rst_n) begin
            cfg_mirror.radius = RADIUS_RST;
            cfg_mirror.recip  = RECIP_RST;
            cfg_mirror.norm   = NORM_RST;
        end else begin
            if (o_done) begin
                if (expected_kernel.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    exp_w = expected_kernel.pop_front();
                    if (o_kernel_value !== exp_w.kval) begin
                        $error("kernel_value expected %0d got %0d",
                               $signed(exp_w.kval), o_kernel_value);
                        fail_count++;
                    end
                    if (o_grad_factor !== exp_w.grad) begin
                        $error("grad_factor expected %0d got %0d",
                               $signed(exp_w.grad), o_grad_factor);
                        fail_count++;
                    end
                    if (o_saturated !== exp_w.sat) begin
                        $error("saturated expected %0d got %0d", exp_w.sat, o_saturated);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_kernel.push_back(predict_kernel(i_distance, cfg_mirror));
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_RADIUS: cfg_mirror.radius = pwdata;
                    REG_RECIP:  cfg_mirror.recip  = pwdata;
                    REG_NORM:   cfg_mirror.norm   = pwdata;
                    default: ;
                endcase
            end
        end
    end

    initial fail_count = 0;
    assign o_fail_count = fail_count;
    assign o_pending    = expected_kernel.size();
endmodule

// ----- tb/testbench.sv -----
module testbench;
    import skvg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PIPE_DEPTH     = 45;   // 40 stage pipe plus margin

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_distance = '0;
    logic        o_done;
    logic signed [31:0] o_kernel_value, o_grad_factor;
    logic        o_saturated;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          stall_cycles = 0;
    int          idle_pct = 0;
    int          words_sent = 0;
    int          settings_run = 0;

    always #10 i_clk = ~i_clk;

    sph_kernel_value_gradient dut (.*);

    kernel_checker chk (
        .i_clk, .i_rst_n, .start, .busy, .i_distance, .o_done, .o_kernel_value,
        .o_grad_factor, .o_saturated, .psel, .penable, .pwrite, .paddr, .pwdata,
        .pready, .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog: any accepted word, result or register write counts as progress
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable) || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // two-phase apb write, completes when pready is seen high
    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        logic rdy;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = pready;
            @(posedge i_clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // present one word; start stays high across back-to-back words
    task automatic send_word(logic [31:0] d);
        logic b;
        start      <= 1'b1;
        i_distance <= d;
        do begin
            @(negedge i_clk);
            b = busy;
            @(posedge i_clk);
        end while (b);
        words_sent++;
        // random sender idle cycles, idle_pct percent of cycles on average
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // pipe must be empty before the registers change
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    task automatic load_setting(logic [31:0] h, logic [31:0] inv_h, logic [31:0] sigma);
        drain();
        write_reg(REG_RADIUS, h);
        write_reg(REG_RECIP, inv_h);
        write_reg(REG_NORM, sigma);
        settings_run++;
    endtask

    // distance biased into the support of the current reciprocal
    function automatic logic [31:0] pick_distance(logic [31:0] inv_h);
        logic [63:0] span;
        int          sel;
        sel  = $urandom_range(99);
        span = (inv_h == 0) ? 64'hFFFF_FFFF : ((64'h1 << 32) / inv_h) + 2;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        if (sel < 60)
            return $urandom_range(span[31:0]);
        else if (sel < 70)
            return span[31:0] / 2 + $urandom_range(3) - 1;  // around q = 0.5
        else if (sel < 75)
            return $urandom_range(1);
        else
            return $urandom();
    endfunction

    logic [31:0] directed_list[] = '{
        32'h0, 32'h1, 32'h2, 32'h4000, 32'h7FFF, 32'h8000, 32'h8001, 32'hC000,
        32'hFFFF, 32'h1_0000, 32'h1_0001, 32'h2_0000, 32'h8000_0000, 32'hFFFF_FFFF,
        32'h5555_5555, 32'hAAAA_AAAA
    };

    // support radius, reciprocal, sigma per setting: nominal, h = 2, h = 0.5,
    // all-ones extremes, tiny radius, inconsistent reciprocal, huge sigma
    logic [31:0] set_h[]   = '{32'h1_0000, 32'h2_0000, 32'h8000, 32'hFFFF_FFFF,
                               32'h1, 32'h1_0000, 32'h1_0000};
    logic [31:0] set_inv[] = '{32'h1_0000, 32'h8000, 32'h2_0000, 32'hFFFF_FFFF,
                               32'h0, 32'h3_0D40, 32'h1_0000};
    logic [31:0] set_sig[] = '{32'd166886, 32'd20861, 32'd1335088, 32'hFFFF_FFFF,
                               32'h0, 32'd166886, 32'hFFFF_FFFF};

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at reset values, no idling
        foreach (directed_list[i]) send_word(directed_list[i]);

        // random words over each register setting: light sender idling first,
        // then heavy idling, then none
        foreach (set_h[s]) begin
            load_setting(set_h[s], set_inv[s], set_sig[s]);
            case (s)
                0, 1, 2: idle_pct = 30;
                3, 4:    idle_pct = 85;
                default: idle_pct = 0;
            endcase
            repeat (135) send_word(pick_distance(set_inv[s]));
        end
        // back to reset values, back to back for the tail
        load_setting(RADIUS_RST, RECIP_RST, NORM_RST);
        idle_pct = 0;
        repeat (40) send_word(pick_distance(RECIP_RST));

        drain();
        $display("covered %0d words across %0d register settings plus reset values",
                 words_sent, settings_run);
        $display("settings included tiny radius, zero reciprocal and saturating sigma");
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/skvg_pkg.sv
rtl/skvg_regs.sv
rtl/skvg_front.sv
rtl/skvg_div.sv
rtl/sph_kernel_value_gradient.sv
tb/kernel_checker.sv
tb/testbench.sv
